// ----- sv/fbgtm_pkg.sv -----
package fbgtm_pkg;

  localparam int unsigned MaxWindowDef  = 16384;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned BinCountDef   = 5;
  localparam int unsigned CoefRegs      = 5;
  localparam int unsigned CoefW         = 19;
  localparam int unsigned StateW        = 48;
  localparam int unsigned WinW          = 15;
  localparam int unsigned PowW          = 32;
  localparam int unsigned RmsW          = 16;
  localparam int unsigned AddrW         = 5;

  localparam logic [2:0] RegWindow = 3'd0;
  localparam logic [2:0] RegCoef0  = 3'd1;
  localparam logic [2:0] RegCoef4  = 3'd5;
  localparam logic [2:0] RegEnable = 3'd6;

  localparam logic [StateW-1:0] StateMax = {1'b0, {(StateW-1){1'b1}}};
  localparam logic [StateW-1:0] StateMin = {1'b1, {(StateW-1){1'b0}}};

  typedef struct packed {
    logic [WinW-1:0] n;
    logic            last;
  } fe_ctl_t;

endpackage

// ----- sv/fbgtm_front.sv -----
module fbgtm_front import fbgtm_pkg::*; #(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic [WinW-1:0]              window_length_i,
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output logic signed [SampleBits-1:0] q_sample_o,
  output fe_ctl_t                      q_ctl_o
);

  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam logic [CntW-1:0] MaxN = CntW'(MaxWindow);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_clamp;
  logic [CntW-1:0] wl_ext;
  logic            acc;
  logic            last;
  logic [1:0]      fill_q, fill_d;
  logic signed [SampleBits-1:0] smp_q [2];
  fe_ctl_t         ctl_q [2];
  logic            wr_q, wr_d, rd_q, rd_d;

  always_comb begin
    wl_ext = (CntW >= WinW) ? CntW'(window_length_i) : CntW'(window_length_i);
    if (CntW > WinW && window_length_i > WinW'(MaxWindow > 32767 ? 32767 : MaxWindow))
      n_clamp = MaxN;
    else if (window_length_i < WinW'(8))
      n_clamp = CntW'(8);
    else if ({{(32-WinW){1'b0}}, window_length_i} > MaxWindow)
      n_clamp = MaxN;
    else
      n_clamp = wl_ext;
  end

  assign sample_ready_o = (fill_q != 2'd2);
  assign acc  = sample_valid_i & sample_ready_o;
  assign last = (cnt_q + CntW'(1)) >= n_clamp;

  always_comb begin
    cnt_d = cnt_q;
    if (acc) cnt_d = last ? '0 : cnt_q + CntW'(1);
  end

  assign q_valid_o  = (fill_q != 2'd0);
  assign q_sample_o = smp_q[rd_q];
  assign q_ctl_o    = ctl_q[rd_q];

  always_comb begin
    fill_d = fill_q;
    wr_d   = wr_q;
    rd_d   = rd_q;
    if (acc) wr_d = ~wr_q;
    if (q_valid_o && q_ready_i) rd_d = ~rd_q;
    if (acc && !(q_valid_o && q_ready_i)) fill_d = fill_q + 2'd1;
    else if (!acc && q_valid_o && q_ready_i) fill_d = fill_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fill_q <= '0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      smp_q[wr_q]      <= sample_i;
      ctl_q[wr_q].n    <= WinW'(n_clamp);
      ctl_q[wr_q].last <= last;
    end
  end

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("queue overfill");
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < MaxN)
    else $error("counter out of range");
  a_full_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0 || fill_q == 2'd2) |-> wr_q == rd_q)
    else $error("pointer mismatch");

endmodule

// ----- sv/fbgtm_back.sv -----
module fbgtm_back import fbgtm_pkg::*; #(
  parameter int unsigned SampleBits = SampleBitsDef,
  parameter int unsigned BinCount   = BinCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  logic signed [SampleBits-1:0] q_sample_i,
  input  fe_ctl_t                      q_ctl_i,
  input  logic signed [CoefW-1:0]      coef_i [CoefRegs],
  input  logic [CoefRegs-1:0]          bin_enable_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [RmsW-1:0]              rms_level_o,
  output logic [PowW-1:0]              power_o [CoefRegs],
  output logic [WinW-1:0]              samples_used_o
);

  localparam int unsigned UsedBins = (BinCount < CoefRegs) ? BinCount : CoefRegs;
  localparam int unsigned NormShift = 2 * SampleBits - 12;
  localparam int unsigned PW = 2 * StateW + 16 + 4;
  localparam int unsigned QW = PW;
  localparam int unsigned DW = 2 * WinW + 2;
  localparam int unsigned EW = 64;
  localparam int unsigned MW = 64;
  localparam int unsigned MeanUp   = (SampleBits <= 16) ? 2 * (16 - SampleBits) : 0;
  localparam int unsigned MeanDown = (SampleBits > 16) ? 2 * (SampleBits - 16) : 0;

  localparam logic [3:0] StRun  = 4'd0;
  localparam logic [3:0] StMul1 = 4'd1;
  localparam logic [3:0] StMul2 = 4'd2;
  localparam logic [3:0] StMul3 = 4'd3;
  localparam logic [3:0] StSum  = 4'd4;
  localparam logic [3:0] StDiv  = 4'd5;
  localparam logic [3:0] StNext = 4'd6;
  localparam logic [3:0] StMean = 4'd7;
  localparam logic [3:0] StSqrt = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0] st_q, st_d;
  logic signed [StateW-1:0] s1_q [UsedBins];
  logic signed [StateW-1:0] s2_q [UsedBins];
  logic [EW-1:0]            en_q;
  logic [WinW-1:0]          n_q;

  logic                     take;
  logic signed [SampleBits-1:0] x;

  // resonator update, one sample per cycle for all bins while the back end is in its run state
  logic signed [StateW-17:0] hi   [UsedBins];
  logic        [15:0]        lo   [UsedBins];
  logic signed [StateW+CoefW-1:0] pm  [UsedBins];
  logic signed [CoefW+17:0]  plo  [UsedBins];
  logic signed [StateW+CoefW+1:0] s0w [UsedBins];

  always_comb begin
    for (int b = 0; b < UsedBins; b++) begin
      hi[b]  = s1_q[b][StateW-1:16];
      lo[b]  = s1_q[b][15:0];
      pm[b]  = coef_i[b] * hi[b];
      plo[b] = coef_i[b] * $signed({1'b0, lo[b]}) + signed'((CoefW+18)'(32768));
      s0w[b] = (StateW+CoefW+2)'(x) + (StateW+CoefW+2)'(pm[b])
             + (StateW+CoefW+2)'(plo[b] >>> 16) - (StateW+CoefW+2)'(s2_q[b]);
    end
  end

  assign x = q_sample_i;
  assign q_ready_o = (st_q == StRun);
  assign take = q_valid_i & q_ready_o;

  // window end: power, division, sqrt on shared sequential units
  logic [2:0]         bin_q;
  logic [StateW-1:0]  m1_q, m2_q;
  logic [CoefW-1:0]   mc_q;
  logic               neg_q;
  logic [2*StateW-1:0] a1_q, a2_q, t0_q;
  logic [2*StateW-1:0] sh1_q, sh2_q;
  logic [2*StateW-1:0] a1_nx, a2_nx, t0_nx;
  logic [2*StateW+CoefW-1:0] t_q, tsh_q;
  logic [PW-1:0]      p_q;
  logic [QW-1:0]      q_q;
  logic [DW+1:0]      rem_q;
  logic [DW-1:0]      d_q;
  logic [6:0]         it_q;
  logic [PowW-1:0]    pw_q [CoefRegs];
  logic [MW-1:0]      ev_q, sr_q, sb_q;
  logic [PowW-1:0]    rpow;
  logic               qbit;
  logic [DW+1:0]      rem_sh;
  logic [StateW-1:0]  ab1, ab2;
  logic [CoefW-1:0]   abc;
  logic [PW-1:0]      aw, tw, pw_s;

  always_comb begin
    ab1 = s1_q[bin_q][StateW-1] ? -s1_q[bin_q] : s1_q[bin_q];
    ab2 = s2_q[bin_q][StateW-1] ? -s2_q[bin_q] : s2_q[bin_q];
    abc = coef_i[bin_q][CoefW-1] ? -coef_i[bin_q] : coef_i[bin_q];
    a1_nx = m1_q[0] ? a1_q + sh1_q : a1_q;
    a2_nx = m2_q[0] ? a2_q + sh2_q : a2_q;
    t0_nx = m2_q[0] ? t0_q + sh1_q : t0_q;
    aw  = (PW'(a1_q) + PW'(a2_q)) << 16;
    tw  = PW'(t_q);
    pw_s = neg_q ? aw + tw : aw - tw;
    rem_sh = {rem_q[DW:0], p_q[PW-1]};
    qbit = rem_sh >= (DW+2)'(d_q);
    rpow = (q_q[QW-1:PowW] != '0) ? '1 : q_q[PowW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StRun;
      for (int b = 0; b < UsedBins; b++) begin
        s1_q[b] <= '0;
        s2_q[b] <= '0;
      end
      en_q  <= '0;
      bin_q <= '0;
    end else begin
      st_q <= st_d;
      if (take) begin
        en_q <= en_q + EW'(x * x);
        for (int b = 0; b < UsedBins; b++) begin
          s2_q[b] <= s1_q[b];
          if (s0w[b] > (StateW+CoefW+2)'(signed'(StateMax)))      s1_q[b] <= StateMax;
          else if (s0w[b] < (StateW+CoefW+2)'(signed'(StateMin))) s1_q[b] <= StateMin;
          else s1_q[b] <= StateW'(s0w[b]);
        end
        bin_q <= '0;
      end
      if (st_q == StNext) bin_q <= bin_q + 3'd1;
      if (st_q == StOut && out_ready_i) begin
        en_q <= '0;
        for (int b = 0; b < UsedBins; b++) begin
          s1_q[b] <= '0;
          s2_q[b] <= '0;
        end
      end
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StRun:  if (take && q_ctl_i.last) st_d = StMul1;
      StMul1: st_d = StMul2;
      StMul2: if (it_q == 7'd0) st_d = StMul3;
      StMul3: if (it_q == 7'd0) st_d = StSum;
      StSum:  st_d = StDiv;
      StDiv:  if (it_q == 7'd0) st_d = StNext;
      StNext: st_d = (32'(bin_q) + 1 >= UsedBins) ? StMean : StMul1;
      StMean: if (it_q == 7'd0) st_d = StSqrt;
      StSqrt: if (sb_q == MW'(1)) st_d = StOut;
      StOut:  if (out_ready_i) st_d = StRun;
      default: st_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take && q_ctl_i.last) begin
      n_q <= q_ctl_i.n;
      d_q <= DW'(q_ctl_i.n) * DW'(q_ctl_i.n);
      for (int b = 0; b < CoefRegs; b++) pw_q[b] <= '0;
    end
    case (st_q)
      StMul1: begin
        m1_q  <= ab1;
        m2_q  <= ab2;
        mc_q  <= abc;
        neg_q <= (s1_q[bin_q][StateW-1] ^ s2_q[bin_q][StateW-1]) ^ coef_i[bin_q][CoefW-1];
        sh1_q <= (2*StateW)'(ab1);
        sh2_q <= (2*StateW)'(ab2);
        a1_q  <= '0;
        a2_q  <= '0;
        t0_q  <= '0;
        it_q  <= 7'(StateW - 1);
      end
      StMul2: begin
        a1_q  <= a1_nx;
        a2_q  <= a2_nx;
        t0_q  <= t0_nx;
        m1_q  <= m1_q >> 1;
        m2_q  <= m2_q >> 1;
        sh1_q <= sh1_q << 1;
        sh2_q <= sh2_q << 1;
        if (it_q == 7'd0) begin
          tsh_q <= (2*StateW+CoefW)'(t0_nx);
          t_q   <= '0;
          it_q  <= 7'(CoefW - 1);
        end else begin
          it_q  <= it_q - 7'd1;
        end
      end
      StMul3: begin
        if (mc_q[0]) t_q <= t_q + tsh_q;
        mc_q  <= mc_q >> 1;
        tsh_q <= tsh_q << 1;
        it_q  <= it_q - 7'd1;
      end
      StSum: begin
        p_q   <= pw_s[PW-1] ? '0 : pw_s >> NormShift;
        q_q   <= '0;
        rem_q <= '0;
        it_q  <= 7'(PW - 1);
      end
      StDiv: begin
        rem_q <= qbit ? rem_sh - (DW+2)'(d_q) : rem_sh;
        q_q   <= {q_q[QW-2:0], qbit};
        p_q   <= p_q << 1;
        it_q  <= it_q - 7'd1;
      end
      StNext: begin
        if (bin_enable_i[bin_q]) pw_q[bin_q] <= rpow;
        p_q   <= PW'(en_q) << (MeanUp + (PW - EW));
        q_q   <= '0;
        rem_q <= '0;
        if (32'(bin_q) + 1 >= UsedBins) d_q <= DW'(n_q);
        it_q  <= 7'(EW - 1);
      end
      StMean: begin
        rem_q <= qbit ? rem_sh - (DW+2)'(d_q) : rem_sh;
        q_q   <= {q_q[QW-2:0], qbit};
        p_q   <= p_q << 1;
        it_q  <= it_q - 7'd1;
        if (it_q == 7'd0) begin
          ev_q <= MW'({q_q[QW-2:0], qbit}) >> MeanDown;
          sr_q <= '0;
          sb_q <= MW'(1) << 62;
        end
      end
      StSqrt: begin
        if (ev_q >= sr_q + sb_q) begin
          ev_q <= ev_q - (sr_q + sb_q);
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = (st_q == StOut);
  assign rms_level_o    = (sr_q > MW'(32768)) ? RmsW'(32768) : RmsW'(sr_q);
  assign samples_used_o = n_q;
  assign power_o        = pw_q;

  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StRun |-> !take) else $error("sample taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_bin_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bin_q) <= UsedBins) else $error("bin index out of range");

endmodule

// ----- sv/five_bin_goertzel_tone_meter.sv -----
// Window result: after the last sample of the window is accepted it passes through the
// queue, then each used bin (at most five) runs a set-up step, a shift-add multiply, a
// second set-up step and a bitwise division, followed by the mean division and the
// square root.
// Throughput: one sample per cycle within a window; the two-entry queue takes two more
// samples, then input stalls until the result transaction is accepted.
// Reset: asynchronous, active low; registers to defaults, resonators cleared.
module five_bin_goertzel_tone_meter import fbgtm_pkg::*; #(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef,
  parameter int unsigned BinCount   = BinCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [AddrW-1:0]             paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                         result_valid_o,
  input  logic                         result_ready_i,
  output logic [RmsW-1:0]              rms_level_o,
  output logic [PowW-1:0]              target_power_o,
  output logic [PowW-1:0]              minus_one_power_o,
  output logic [PowW-1:0]              plus_one_power_o,
  output logic [PowW-1:0]              minus_two_power_o,
  output logic [PowW-1:0]              plus_two_power_o,
  output logic [WinW-1:0]              samples_used_o
);

  logic [WinW-1:0]          wl_q;
  logic signed [CoefW-1:0]  coef_q [CoefRegs];
  logic [CoefRegs-1:0]      en_q;
  logic [2:0]               idx;
  logic                     wr;
  logic                     qv, qr;
  logic signed [SampleBits-1:0] qs;
  fe_ctl_t                  qc;
  logic [PowW-1:0]          pw [CoefRegs];

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WinW'(2048);
      for (int i = 0; i < CoefRegs; i++) coef_q[i] <= '0;
      en_q <= '1;
    end else if (wr) begin
      if (idx == RegWindow) wl_q <= pwdata[WinW-1:0];
      else if (idx >= RegCoef0 && idx <= RegCoef4) coef_q[idx - RegCoef0] <= pwdata[CoefW-1:0];
      else if (idx == RegEnable) en_q <= pwdata[CoefRegs-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == RegWindow) prdata = 32'(wl_q);
    else if (idx >= RegCoef0 && idx <= RegCoef4)
      prdata = 32'(signed'(coef_q[idx - RegCoef0]));
    else if (idx == RegEnable) prdata = 32'(en_q);
  end

  fbgtm_front #(.MaxWindow(MaxWindow), .SampleBits(SampleBits)) u_front (
    .clk_i, .rst_ni, .sample_valid_i, .sample_ready_o, .sample_i,
    .window_length_i(wl_q),
    .q_valid_o(qv), .q_ready_i(qr), .q_sample_o(qs), .q_ctl_o(qc)
  );

  fbgtm_back #(.SampleBits(SampleBits), .BinCount(BinCount)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_sample_i(qs), .q_ctl_i(qc),
    .coef_i(coef_q), .bin_enable_i(en_q),
    .out_valid_o(result_valid_o), .out_ready_i(result_ready_i),
    .rms_level_o, .power_o(pw), .samples_used_o
  );

  assign target_power_o    = pw[0];
  assign minus_one_power_o = pw[1];
  assign plus_one_power_o  = pw[2];
  assign minus_two_power_o = pw[3];
  assign plus_two_power_o  = pw[4];

endmodule
